/* hdl/osle_pkg.sv */
package osle_pkg;

   localparam int CMD_W = 4;
   localparam int VAL_W = 32;
   localparam int POS_W = 7;
   localparam int ST_W  = 3;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [ST_W-1:0]  status_type;
   typedef logic [VAL_W-1:0] word_type;
   typedef logic [POS_W-1:0] pos_type;

   localparam cmd_type CMD_INS_FRONT  = 4'd0;
   localparam cmd_type CMD_INS_REAR   = 4'd1;
   localparam cmd_type CMD_DEL_FRONT  = 4'd2;
   localparam cmd_type CMD_DEL_REAR   = 4'd3;
   localparam cmd_type CMD_INS_AT     = 4'd4;
   localparam cmd_type CMD_DEL_AT     = 4'd5;
   localparam cmd_type CMD_REVERSE    = 4'd6;
   localparam cmd_type CMD_SEARCH     = 4'd7;
   localparam cmd_type CMD_UPDATE     = 4'd8;
   localparam cmd_type CMD_DEL_KEY    = 4'd9;
   localparam cmd_type CMD_SORT       = 4'd10;
   localparam cmd_type CMD_SORTED_INS = 4'd11;
   localparam cmd_type CMD_DUMP       = 4'd12;

   localparam status_type ST_OK     = 3'd0;
   localparam status_type ST_EMPTY  = 3'd1;
   localparam status_type ST_BADPOS = 3'd2;
   localparam status_type ST_NOKEY  = 3'd3;
   localparam status_type ST_FULL   = 3'd4;

endpackage

/* hdl/osle_req_if.sv */
interface osle_req_if;
   logic              valid;
   logic              ready;
   osle_pkg::cmd_type command;
   logic signed [31:0] value;
   logic signed [31:0] key;
   osle_pkg::pos_type position;

   modport source (output valid, command, value, key, position, input ready);
   modport sink   (input valid, command, value, key, position, output ready);
endinterface

/* hdl/osle_rsp_if.sv */
interface osle_rsp_if;
   logic                 valid;
   logic                 ready;
   osle_pkg::status_type status;
   osle_pkg::pos_type    position_res;
   logic signed [31:0]   value_res;
   osle_pkg::pos_type    count;
   logic                 last;

   modport source (output valid, status, position_res, value_res, count, last, input ready);
   modport sink   (input valid, status, position_res, value_res, count, last, output ready);
endinterface

/* hdl/osle_ram.sv */
module osle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule

/* hdl/ordered_sequence_list_engine.sv */
// Ordered sequence list engine: a bounded, ordered store of signed 32-bit
// values with list commands (insert, delete, reverse, search, update,
// delete by key, sort, sorted insert, dump).
// Channels: req_if carries one command beat (command, value, key,
// position); rsp_if returns result beats (status, position_res, value_res,
// count, last). Every command but a dump of a non-empty list gives one beat
// with last set; that dump gives a beat per element, last on the final one.
// Elements live in a two-read, one-write RAM; a sequencer walks it with one
// shared compare/move step, each step a read state then an execute state;
// reverse adds a second write state and dump an output state.
// req_if.ready is high whenever the sequencer is idle and reset is low, also
// while a result beat still waits in the output register.
// Reset clears the count and the handshake state; RAM contents are not
// cleared. A stalled receiver holds the result beat in place; a dump or a
// final beat waits for the slot to free before the walk advances.
module ordered_sequence_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   osle_req_if.sink   req_if,
   osle_rsp_if.source rsp_if
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD   = 4'd1;
   localparam logic [3:0] S_EX   = 4'd2;
   localparam logic [3:0] S_EX2  = 4'd3;
   localparam logic [3:0] S_SRD0 = 4'd4;
   localparam logic [3:0] S_SEX0 = 4'd5;
   localparam logic [3:0] S_SFIN = 4'd6;
   localparam logic [3:0] S_EMIT = 4'd7;
   localparam logic [3:0] S_DOUT = 4'd8;

   localparam logic [2:0] OP_INS  = 3'd0;
   localparam logic [2:0] OP_DEL  = 3'd1;
   localparam logic [2:0] OP_REV  = 3'd2;
   localparam logic [2:0] OP_FIND = 3'd3;
   localparam logic [2:0] OP_SORT = 3'd4;
   localparam logic [2:0] OP_SPOS = 3'd5;
   localparam logic [2:0] OP_DUMP = 3'd6;

   logic [3:0]            state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [CW-1:0]         p_ff, p_in;
   logic                  sins_ff, sins_in;
   osle_pkg::cmd_type     cmd_ff, cmd_in;
   osle_pkg::word_type    val_ff, val_in;
   osle_pkg::word_type    key_ff, key_in;
   osle_pkg::word_type    carry_ff, carry_in;
   osle_pkg::status_type  st_ff, st_in;
   osle_pkg::pos_type     fpos_ff, fpos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   osle_pkg::status_type  rsp_status_ff, rsp_status_in;
   osle_pkg::pos_type     rsp_pos_ff, rsp_pos_in;
   osle_pkg::word_type    rsp_val_ff, rsp_val_in;
   osle_pkg::pos_type     rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  we;
   logic [IW-1:0]         waddr, raddr_a, raddr_b;
   osle_pkg::word_type    wdata, rdata_a, rdata_b;

   logic [CW-1:0]         i_ext, i_p1, rev_hi, n_m1;
   logic [IW-1:0]         pm1;
   logic                  em_ok, rd_lt_carry, rd_lt_val;
   logic [7:0]            pos8, n8;

   osle_ram #(.WIDTH(osle_pkg::VAL_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .rdata_a (rdata_a),
      .raddr_b (raddr_b),
      .rdata_b (rdata_b)
   );

   assign i_ext  = CW'(i_ff);
   assign i_p1   = i_ext + CW'(1);
   assign n_m1   = count_ff - CW'(1);
   assign rev_hi = n_m1 - i_ext;
   assign pos8   = 8'(req_if.position);
   assign n8     = 8'(count_ff);
   assign pm1    = IW'(req_if.position - osle_pkg::pos_type'(1));
   assign em_ok  = !rsp_valid_ff || rsp_if.ready;
   assign rd_lt_carry = $signed(rdata_a) < $signed(carry_ff);
   assign rd_lt_val   = $signed(rdata_a) < $signed(val_ff);

   assign req_if.ready        = (state_ff == S_IDLE) && !reset;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.position_res = rsp_pos_ff;
   assign rsp_if.value_res    = rsp_val_ff;
   assign rsp_if.count        = rsp_cnt_ff;
   assign rsp_if.last         = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      count_in = count_ff;
      i_in     = i_ff;
      p_in     = p_ff;
      sins_in  = sins_ff;
      cmd_in   = cmd_ff;
      val_in   = val_ff;
      key_in   = key_ff;
      carry_in = carry_ff;
      st_in    = st_ff;
      fpos_in  = fpos_ff;
      we       = 1'b0;
      waddr    = i_ff;
      wdata    = carry_ff;
      raddr_a  = i_ff;
      raddr_b  = rev_hi[IW-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.command;
               val_in   = req_if.value;
               key_in   = req_if.key;
               carry_in = req_if.value;
               st_in    = osle_pkg::ST_OK;
               fpos_in  = '0;
               sins_in  = 1'b0;
               i_in     = '0;
               p_in     = CW'(1);
               state_in = S_EMIT;
               unique case (req_if.command)
                  osle_pkg::CMD_INS_FRONT, osle_pkg::CMD_INS_REAR: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        st_in = osle_pkg::ST_FULL;
                     end else begin
                        op_in    = OP_INS;
                        i_in     = (req_if.command == osle_pkg::CMD_INS_FRONT) ?
                                   '0 : count_ff[IW-1:0];
                        state_in = S_RD;
                     end
                  end
                  osle_pkg::CMD_DEL_FRONT, osle_pkg::CMD_DEL_REAR: begin
                     if (count_ff == '0) begin
                        st_in = osle_pkg::ST_EMPTY;
                     end else begin
                        op_in    = OP_DEL;
                        i_in     = (req_if.command == osle_pkg::CMD_DEL_FRONT) ?
                                   '0 : n_m1[IW-1:0];
                        state_in = S_RD;
                     end
                  end
                  osle_pkg::CMD_INS_AT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        st_in = osle_pkg::ST_FULL;
                     end else if (pos8 == 8'd0 || pos8 > n8 + 8'd1) begin
                        st_in = osle_pkg::ST_BADPOS;
                     end else begin
                        op_in    = OP_INS;
                        i_in     = pm1;
                        state_in = S_RD;
                     end
                  end
                  osle_pkg::CMD_DEL_AT: begin
                     if (pos8 == 8'd0 || pos8 > n8) begin
                        st_in = osle_pkg::ST_BADPOS;
                     end else begin
                        op_in    = OP_DEL;
                        i_in     = pm1;
                        state_in = S_RD;
                     end
                  end
                  osle_pkg::CMD_REVERSE: begin
                     if (count_ff == '0) begin
                        st_in = osle_pkg::ST_EMPTY;
                     end else if (count_ff != CW'(1)) begin
                        op_in    = OP_REV;
                        state_in = S_RD;
                     end
                  end
                  osle_pkg::CMD_SEARCH, osle_pkg::CMD_UPDATE, osle_pkg::CMD_DEL_KEY: begin
                     if (count_ff == '0) begin
                        st_in = osle_pkg::ST_EMPTY;
                     end else begin
                        op_in    = OP_FIND;
                        state_in = S_RD;
                     end
                  end
                  osle_pkg::CMD_SORT: begin
                     if (count_ff == '0) begin
                        st_in = osle_pkg::ST_EMPTY;
                     end else if (count_ff != CW'(1)) begin
                        op_in    = OP_SORT;
                        state_in = S_SRD0;
                     end
                  end
                  osle_pkg::CMD_SORTED_INS: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        st_in = osle_pkg::ST_FULL;
                     end else if (count_ff == '0) begin
                        op_in    = OP_INS;
                        state_in = S_RD;
                     end else if (count_ff == CW'(1)) begin
                        op_in    = OP_SPOS;
                        state_in = S_RD;
                     end else begin
                        op_in    = OP_SORT;
                        sins_in  = 1'b1;
                        state_in = S_SRD0;
                     end
                  end
                  osle_pkg::CMD_DUMP: begin
                     if (count_ff == '0) begin
                        st_in = osle_pkg::ST_EMPTY;
                     end else begin
                        op_in    = OP_DUMP;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     st_in = osle_pkg::ST_OK;
                  end
               endcase
            end
         end

         S_RD: begin
            // issue the read for this step; a delete of the tail slot needs none
            unique case (op_ff)
               OP_DEL: begin
                  raddr_a = i_p1[IW-1:0];
                  if (i_p1 == count_ff) begin
                     count_in = n_m1;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_EX;
                  end
               end
               OP_SORT: begin
                  raddr_a  = i_p1[IW-1:0];
                  state_in = S_EX;
               end
               default: begin
                  state_in = S_EX;
               end
            endcase
         end

         S_EX: begin
            unique case (op_ff)
               OP_INS: begin
                  // ripple the carried value one slot toward the tail
                  we       = 1'b1;
                  wdata    = carry_ff;
                  carry_in = rdata_a;
                  if (i_ext == count_ff) begin
                     count_in = count_ff + CW'(1);
                     state_in = S_EMIT;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     state_in = S_RD;
                  end
               end
               OP_DEL: begin
                  we       = 1'b1;
                  wdata    = rdata_a;
                  i_in     = i_ff + IW'(1);
                  state_in = S_RD;
               end
               OP_REV: begin
                  we       = 1'b1;
                  wdata    = rdata_b;
                  carry_in = rdata_a;
                  state_in = S_EX2;
               end
               OP_FIND: begin
                  if (rdata_a == key_ff) begin
                     if (cmd_ff == osle_pkg::CMD_SEARCH) begin
                        fpos_in  = osle_pkg::pos_type'(i_p1);
                        state_in = S_EMIT;
                     end else if (cmd_ff == osle_pkg::CMD_UPDATE) begin
                        we       = 1'b1;
                        wdata    = val_ff;
                        state_in = S_EMIT;
                     end else begin
                        op_in    = OP_DEL;
                        state_in = S_RD;
                     end
                  end else if (i_p1 == count_ff) begin
                     st_in    = osle_pkg::ST_NOKEY;
                     state_in = S_EMIT;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     state_in = S_RD;
                  end
               end
               OP_SORT: begin
                  // keep the larger value moving, drop the smaller into slot i
                  we    = 1'b1;
                  wdata = rd_lt_carry ? rdata_a : carry_ff;
                  if (!rd_lt_carry) begin
                     carry_in = rdata_a;
                  end
                  if (i_p1 == n_m1) begin
                     state_in = S_SFIN;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     state_in = S_RD;
                  end
               end
               OP_SPOS: begin
                  carry_in = val_ff;
                  if (!rd_lt_val) begin
                     op_in    = OP_INS;
                     state_in = S_RD;
                  end else if (i_p1 == count_ff) begin
                     op_in    = OP_INS;
                     i_in     = count_ff[IW-1:0];
                     state_in = S_RD;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     state_in = S_RD;
                  end
               end
               default: begin
                  carry_in = rdata_a;
                  state_in = S_DOUT;
               end
            endcase
         end

         S_EX2: begin
            we    = 1'b1;
            waddr = rev_hi[IW-1:0];
            wdata = carry_ff;
            if (i_p1 == (count_ff >> 1)) begin
               state_in = S_EMIT;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = S_RD;
            end
         end

         S_SRD0: begin
            raddr_a  = '0;
            state_in = S_SEX0;
         end

         S_SEX0: begin
            carry_in = rdata_a;
            i_in     = '0;
            state_in = S_RD;
         end

         S_SFIN: begin
            we    = 1'b1;
            waddr = n_m1[IW-1:0];
            wdata = carry_ff;
            p_in  = p_ff + CW'(1);
            if (p_ff + CW'(1) == count_ff) begin
               if (sins_ff) begin
                  op_in    = OP_SPOS;
                  i_in     = '0;
                  state_in = S_RD;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               state_in = S_SRD0;
            end
         end

         S_DOUT: begin
            if (em_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = osle_pkg::ST_OK;
               rsp_pos_in    = osle_pkg::pos_type'(i_p1);
               rsp_val_in    = carry_ff;
               rsp_cnt_in    = osle_pkg::pos_type'(count_ff);
               rsp_last_in   = (i_p1 == count_ff);
               if (i_p1 == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = S_RD;
               end
            end
         end

         S_EMIT: begin
            if (em_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_pos_in    = fpos_ff;
               rsp_val_in    = '0;
               rsp_cnt_in    = osle_pkg::pos_type'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      i_ff          <= i_in;
      p_ff          <= p_in;
      sins_ff       <= sins_in;
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      carry_ff      <= carry_in;
      st_ff         <= st_in;
      fpos_ff       <= fpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // a command beat always starts the sequencer
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after a command beat");

   // the count moves only while a command is being worked
   a_count_steady_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |=> count_ff == $past(count_ff))
      else $error("count changed outside a command");

   // sort passes stay within n-1
   a_sort_pass_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRD0 |-> p_ff < count_ff)
      else $error("sort pass count ran past the list length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.count <= osle_pkg::pos_type'(CAPACITY))
      else $error("reported count exceeds capacity");
endmodule

/* dv/ordered_sequence_list_engine_tb.sv */
`timescale 1ns / 1ps

module ordered_sequence_list_engine_tb;
   import osle_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 20000000;

   // One command beat as the driver presents it.
   typedef struct {
      cmd_type            command;
      logic signed [31:0] value;
      logic signed [31:0] key;
      pos_type            position;
   } list_cmd_type;

   // One result beat the block is supposed to return.
   typedef struct {
      status_type         status;
      pos_type            position_res;
      logic signed [31:0] value_res;
      pos_type            count;
      logic               last;
   } list_rsp_type;

   logic clock;
   logic reset;

   osle_req_if req_if ();
   osle_rsp_if rsp_if ();

   ordered_sequence_list_engine #(.CAPACITY(CAPACITY)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // Shadow copy of the list contents, advanced as each command is queued.
   // Commands leave in queue order, so the result stream matches this order.
   logic signed [31:0] shadow_elems [CAPACITY];
   int                 shadow_count;
   int                 peak_count;

   list_cmd_type pending_cmds [$];
   list_rsp_type expected_beats [$];

   int total_cmds;
   int cmds_sent;
   int beats_seen;
   int mismatches;
   int cycles;
   bit long_hold_done;

   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // List predictor
   // ---------------------------------------------------------------------
   function automatic void push_result(status_type st, pos_type pos,
                                       logic signed [31:0] val, logic lst);
      list_rsp_type r;
      r.status       = st;
      r.position_res = pos;
      r.value_res    = val;
      r.count        = pos_type'(shadow_count);
      r.last         = lst;
      expected_beats.push_back(r);
   endfunction

   // Open a slot at idx (0-based) and fill it.
   function automatic void shadow_insert(int idx, logic signed [31:0] v);
      for (int i = shadow_count; i > idx; i--)
         shadow_elems[i] = shadow_elems[i-1];
      shadow_elems[idx] = v;
      shadow_count++;
      if (shadow_count > peak_count)
         peak_count = shadow_count;
   endfunction

   // Close the slot at idx (0-based).
   function automatic void shadow_remove(int idx);
      for (int i = idx; i + 1 < shadow_count; i++)
         shadow_elems[i] = shadow_elems[i+1];
      shadow_count--;
   endfunction

   function automatic void shadow_sort();
      logic signed [31:0] t;
      for (int i = 1; i < shadow_count; i++)
         for (int j = 0; j + 1 < shadow_count; j++)
            if (shadow_elems[j+1] < shadow_elems[j]) begin
               t                 = shadow_elems[j];
               shadow_elems[j]   = shadow_elems[j+1];
               shadow_elems[j+1] = t;
            end
   endfunction

   // 1-based position of the first element equal to k, 0 if none.
   function automatic int shadow_find(logic signed [31:0] k);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_elems[i] == k)
            return i + 1;
      return 0;
   endfunction

   // Apply one command to the shadow list and queue the beats it returns.
   function automatic void predict_list_op(list_cmd_type c);
      int                 n;
      int                 hit;
      int                 slot;
      status_type         st;
      pos_type            found;
      logic signed [31:0] t;
      n     = shadow_count;
      st    = ST_OK;
      found = '0;
      case (c.command)
         CMD_INS_FRONT, CMD_INS_REAR: begin
            if (n >= CAPACITY) st = ST_FULL;
            else shadow_insert((c.command == CMD_INS_FRONT) ? 0 : n, c.value);
         end
         CMD_DEL_FRONT, CMD_DEL_REAR: begin
            if (n == 0) st = ST_EMPTY;
            else shadow_remove((c.command == CMD_DEL_FRONT) ? 0 : n - 1);
         end
         CMD_INS_AT: begin
            if (n >= CAPACITY) st = ST_FULL;
            else if (c.position < 1 || c.position > n + 1) st = ST_BADPOS;
            else shadow_insert(c.position - 1, c.value);
         end
         CMD_DEL_AT: begin
            if (c.position < 1 || c.position > n) st = ST_BADPOS;
            else shadow_remove(c.position - 1);
         end
         CMD_REVERSE: begin
            if (n == 0) st = ST_EMPTY;
            else
               for (int i = 0; i < n / 2; i++) begin
                  t                   = shadow_elems[i];
                  shadow_elems[i]     = shadow_elems[n-1-i];
                  shadow_elems[n-1-i] = t;
               end
         end
         CMD_SEARCH, CMD_UPDATE, CMD_DEL_KEY: begin
            hit = shadow_find(c.key);
            if (n == 0) st = ST_EMPTY;
            else if (hit == 0) st = ST_NOKEY;
            else if (c.command == CMD_SEARCH) found = pos_type'(hit);
            else if (c.command == CMD_UPDATE) shadow_elems[hit-1] = c.value;
            else shadow_remove(hit - 1);
         end
         CMD_SORT: begin
            if (n == 0) st = ST_EMPTY;
            else shadow_sort();
         end
         CMD_SORTED_INS: begin
            if (n >= CAPACITY) st = ST_FULL;
            else begin
               shadow_sort();
               slot = 0;
               while (slot < n && shadow_elems[slot] < c.value)
                  slot++;
               shadow_insert(slot, c.value);
            end
         end
         CMD_DUMP: begin
            // one beat per element, last on the final one
            if (n == 0) st = ST_EMPTY;
            else begin
               for (int i = 0; i < n; i++)
                  push_result(ST_OK, pos_type'(i + 1), shadow_elems[i], i + 1 == n);
               return;
            end
         end
         default: ;  // unknown codes change nothing
      endcase
      push_result(st, found, '0, 1'b1);
   endfunction

   // Queue a command for the driver and predict its results right away.
   function automatic void queue_cmd(cmd_type cmd, logic signed [31:0] val,
                                     logic signed [31:0] k, pos_type pos);
      list_cmd_type c;
      c.command  = cmd;
      c.value    = val;
      c.key      = k;
      c.position = pos;
      pending_cmds.push_back(c);
      predict_list_op(c);
   endfunction

   // Values: small range for duplicates and ties, extremes, or anything.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2, 3:    return $signed(32'($urandom_range(0, 16))) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Keys mostly hit a stored element so search/update/delete get past the miss.
   function automatic logic signed [31:0] pick_key();
      if (shadow_count > 0 && $urandom_range(0, 9) < 7)
         return shadow_elems[$urandom_range(0, shadow_count - 1)];
      return pick_value();
   endfunction

   function automatic pos_type pick_position();
      if ($urandom_range(0, 4) == 0)
         return pos_type'($urandom_range(0, 127));
      return pos_type'($urandom_range(0, shadow_count + 2));
   endfunction

   // Weighted command pick that keeps the list at a handful of elements.
   function automatic cmd_type pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (shadow_count < 4 && r < 40)
         return cmd_type'($urandom_range(0, 1));
      if (shadow_count > 14 && r < 40)
         return cmd_type'($urandom_range(2, 3));
      if (r < 55) return cmd_type'($urandom_range(0, 5));
      if (r < 90) return cmd_type'($urandom_range(6, 12));
      if (r < 95) return CMD_SORTED_INS;
      return cmd_type'($urandom_range(13, 15));
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present queued commands, with random gaps outside the tail
   // ---------------------------------------------------------------------
   int  req_gap;
   bit  req_quiet;
   assign req_quiet = (cmds_sent + 30 >= total_cmds);

   always @(posedge clock) begin
      bit holding;
      holding = req_if.valid && !req_if.ready;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      = 0;
      end else begin
         // advance past the beat taken at this edge
         if (req_if.valid && req_if.ready) begin
            void'(pending_cmds.pop_front());
            cmds_sent++;
         end
         if (!holding && req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_cmds.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (!holding && !req_quiet && $urandom_range(0, 7) == 0) begin
            // start an idle burst; never drop a beat that is still offered
            req_gap = $urandom_range(1, 11) - 1;
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid    <= 1'b1;
            req_if.command  <= pending_cmds[0].command;
            req_if.value    <= pending_cmds[0].value;
            req_if.key      <= pending_cmds[0].key;
            req_if.position <= pending_cmds[0].position;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: take result beats, check them, and stall the result side
   // ---------------------------------------------------------------------
   int rsp_stall;

   always @(posedge clock) begin
      list_rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ordered_sequence_list_engine] ERROR");
         $finish;
      end else if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: status %0d count %0d",
                      rsp_if.status, rsp_if.count);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_if.status);
                  mismatches++;
               end
               if (rsp_if.position_res !== want.position_res) begin
                  $error("position_res: expected %0d actual %0d",
                         want.position_res, rsp_if.position_res);
                  mismatches++;
               end
               if (rsp_if.value_res !== want.value_res) begin
                  $error("value_res: expected %0d actual %0d",
                         want.value_res, rsp_if.value_res);
                  mismatches++;
               end
               if (rsp_if.count !== want.count) begin
                  $error("count: expected %0d actual %0d", want.count, rsp_if.count);
                  mismatches++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0d actual %0d", want.last, rsp_if.last);
                  mismatches++;
               end
            end
         end
         // Hold off once for a long stretch so the block backs up into its
         // command side while the driver keeps offering.
         if (!long_hold_done && cmds_sent >= 40) begin
            long_hold_done = 1'b1;
            rsp_stall      = 400;
            rsp_if.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if (!req_quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(1, 11) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      // known values on every block input from time zero
      req_if.valid    = 1'b0;
      req_if.command  = CMD_DUMP;
      req_if.value    = '0;
      req_if.key      = '0;
      req_if.position = '0;
      rsp_if.ready    = 1'b0;
      reset           = 1'b1;
      shadow_count    = 0;
      peak_count      = 0;
      cmds_sent       = 0;
      beats_seen      = 0;
      mismatches      = 0;
      cycles          = 0;
      long_hold_done  = 1'b0;

      // Directed: every delete, query, reverse, sort and dump command on an empty list first.
      queue_cmd(CMD_DUMP,       0, 0, 0);
      queue_cmd(CMD_DEL_FRONT,  0, 0, 0);
      queue_cmd(CMD_DEL_REAR,   0, 0, 0);
      queue_cmd(CMD_DEL_AT,     0, 0, 1);
      queue_cmd(CMD_REVERSE,    0, 0, 0);
      queue_cmd(CMD_SEARCH,     0, 5, 0);
      queue_cmd(CMD_UPDATE,     1, 5, 0);
      queue_cmd(CMD_DEL_KEY,    0, 5, 0);
      queue_cmd(CMD_SORT,       0, 0, 0);
      queue_cmd(CMD_SORTED_INS, 7, 0, 0);          // sorted insert into empty
      // Extremes and positions at both ends of the legal range.
      queue_cmd(CMD_INS_FRONT,  32'sh7fff_ffff, 0, 0);
      queue_cmd(CMD_INS_REAR,   32'sh8000_0000, 0, 0);
      queue_cmd(CMD_INS_AT,     -1, 0, 0);          // position zero
      queue_cmd(CMD_INS_AT,     -1, 0, 127);
      queue_cmd(CMD_INS_AT,     3, 0, 4);           // append at count+1
      queue_cmd(CMD_SEARCH,     0, 32'sh8000_0000, 0);
      queue_cmd(CMD_SEARCH,     0, 99, 0);          // key absent
      queue_cmd(CMD_UPDATE,     7, 3, 0);           // duplicate 7, first match
      queue_cmd(CMD_SORTED_INS, 7, 0, 0);
      queue_cmd(CMD_REVERSE,    0, 0, 0);
      queue_cmd(CMD_DEL_KEY,    0, 7, 0);
      queue_cmd(CMD_SORT,       0, 0, 0);
      queue_cmd(CMD_DEL_AT,     0, 0, 6);           // two past the end
      queue_cmd(CMD_DUMP,       0, 0, 0);
      queue_cmd(cmd_type'(13),  0, 0, 0);
      queue_cmd(cmd_type'(15),  0, 0, 0);

      // Random commands, with one pass that fills the list to capacity.
      for (int i = 0; i < 60; i++) begin
         if (i == 30) begin
            while (shadow_count < CAPACITY)
               queue_cmd(CMD_INS_REAR, pick_value(), 0, 0);
            queue_cmd(CMD_INS_FRONT,  pick_value(), 0, 0);
            queue_cmd(CMD_INS_AT,     pick_value(), 0, 0);   // full before position
            queue_cmd(CMD_SORTED_INS, pick_value(), 0, 0);
            queue_cmd(CMD_REVERSE,    0, 0, 0);
            queue_cmd(CMD_SEARCH,     0, shadow_elems[CAPACITY-1], 0);
            queue_cmd(CMD_DUMP,       0, 0, 0);
            queue_cmd(CMD_SORT,       0, 0, 0);
            queue_cmd(CMD_DEL_AT,     0, 0, pos_type'(CAPACITY));
            queue_cmd(CMD_DUMP,       0, 0, 0);
            while (shadow_count > 6)
               queue_cmd(CMD_DEL_AT, 0, 0, pos_type'($urandom_range(1, shadow_count)));
         end
         queue_cmd(pick_command(), pick_value(), pick_key(), pick_position());
      end
      total_cmds = pending_cmds.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for every command to go out and every beat to come back
      while (pending_cmds.size() != 0 || expected_beats.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d list commands, %0d result beats, list depth up to %0d of %0d.",
               total_cmds, beats_seen, peak_count, CAPACITY);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("[ordered_sequence_list_engine] OK");
      else
         $display("[ordered_sequence_list_engine] ERROR");
      $finish;
   end

endmodule
